### rtl/lkvc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_pkg
// shared types and codes of the lru/ttl key-value cache
// ----------------------------------------------------------------------------
package lkvc_pkg;

	localparam int DEF_ENTRIES = 256;

	localparam int CNT_W   = 9;
	localparam int BYTES_W = 24;
	localparam int SIZE_W  = 16;
	localparam int TTL_W   = 16;
	localparam int CFG_W   = 24;
	localparam int CFG_IDX_W = 2;
	localparam int TTL_MS_W  = 26;

	localparam logic [TTL_MS_W-1:0] MS_PER_SECOND = TTL_MS_W'(1000);

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TTL_SECONDS = 2'd2;

	localparam logic [CNT_W-1:0]   RST_MAX_ENTRIES = 9'd256;
	localparam logic [BYTES_W-1:0] RST_MAX_BYTES   = 24'd65536;
	localparam logic [TTL_W-1:0]   RST_TTL_SECONDS = 16'd0;

	localparam logic [2:0] MODE_PUT      = 3'd0;
	localparam logic [2:0] MODE_GET      = 3'd1;
	localparam logic [2:0] MODE_REMOVE   = 3'd2;
	localparam logic [2:0] MODE_CONTAINS = 3'd3;
	localparam logic [2:0] MODE_CLEAR    = 3'd4;
	localparam logic [2:0] MODE_STATS    = 3'd5;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND = 3'd1;
	localparam logic [2:0] ST_EXPIRED   = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_BAD_SIZE  = 3'd4;

	typedef struct packed {
		logic [2:0]        mode;
		logic [63:0]       key;
		logic [63:0]       value;
		logic [SIZE_W-1:0] size_bytes;
		logic [63:0]       now_ms;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic               present;
		logic [63:0]        entry_value;
		logic [SIZE_W-1:0]  entry_size;
		logic [CNT_W-1:0]   entries_used;
		logic [BYTES_W-1:0] bytes_used;
		logic [31:0]        hit_count;
		logic [31:0]        miss_count;
		logic [31:0]        eviction_count;
		logic [31:0]        insert_count;
	} rsp_t;

	typedef struct packed {
		logic [63:0]       key;
		logic [63:0]       payload;
		logic [SIZE_W-1:0] bytes;
		logic [63:0]       created;
	} entry_t;

endpackage
`default_nettype wire

### rtl/lkvc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_ram
// single write, single read port memory with registered read data
// ----------------------------------------------------------------------------
module lkvc_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

### rtl/lru_ttl_key_value_cache.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_ttl_key_value_cache
// keyed store with lru replacement, entry and byte limits and time to live
// ----------------------------------------------------------------------------
// steps: key scan, check, plan, then a rank sweep only for ops that change ranks;
//   contains, stats reset, misses and failed puts without eviction skip that sweep
// throughput: one word at a time, set by the key scan and rank sweep over the
//   single read port of each memory, one entry a cycle
// reset: a clearing pass marks every slot empty while req_ready is low
module lru_ttl_key_value_cache import lkvc_pkg::*; #(
	parameter int ENTRIES = DEF_ENTRIES
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_ready,
	input  wire req_t                 req,
	output logic                      rsp_valid,
	input  wire logic                 rsp_ready,
	output rsp_t                      rsp,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata
);

	localparam int AW  = $clog2(ENTRIES);
	localparam int CW  = AW + 1;
	localparam int RKW = AW + 1;
	localparam int EW  = $bits(entry_t);
	localparam logic [CNT_W:0] ENT_CAP = (ENTRIES > 511) ? 10'd511 : 10'(ENTRIES);

	typedef enum logic [2:0] {S_INIT, S_IDLE, S_SCAN, S_CHK, S_PLAN, S_UPD, S_FIN} state_t;

	state_t state_q;

	logic [CNT_W-1:0]   max_entries_q;
	logic [BYTES_W-1:0] max_bytes_q;
	logic [TTL_W-1:0]   ttl_q;

	logic [CW-1:0] cnt_q;
	logic          sweep;
	logic          sweep_end;
	logic          vld_s1;
	logic [AW-1:0] idx_s1;

	req_t   req_q;
	logic   found_q;
	logic [AW-1:0] hidx_q;
	logic [AW-1:0] hrank_q;
	entry_t hent_q;
	logic   vfound_q;
	logic [AW-1:0] vidx_q;
	logic [AW-1:0] vrank_q;
	logic [SIZE_W-1:0] vbytes_q;
	logic   ffound_q;
	logic [AW-1:0] fidx_q;

	logic expired_q, nr1_q, nr2_q;

	logic          kill_en_q, mru_en_q, ins_en_q, clr_q;
	logic [AW-1:0] kill_idx_q, kill_rank_q, mru_idx_q, mru_rank_q, ins_idx_q;

	logic [CNT_W-1:0]   count_q;
	logic [BYTES_W-1:0] bytes_q;
	logic [31:0]        hits_q, miss_q, evict_q, ins_q;
	logic [2:0]         st_q;
	logic               pres_q;
	logic [63:0]        ev_q;
	logic [SIZE_W-1:0]  es_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic           rk_we, rk_re;
	logic [RKW-1:0] rk_wdata, rk_rdata;
	logic           rk_v;
	logic [AW-1:0]  rk_r;
	logic           dt_we, dt_re;
	logic [AW-1:0]  dt_waddr;
	entry_t         dt_wdata;
	logic [EW-1:0]  dt_rdata;
	entry_t         dt_ent;

	logic                upd_v;
	logic [AW-1:0]       upd_r;

	logic [CNT_W:0]      cap;
	logic [TTL_MS_W-1:0] ttl_ms;
	logic [63:0]         age;
	logic                expired_c, nr1_c, nr2_c;
	logic [CNT_W-1:0]    count_m1;
	logic [BYTES_W-1:0]  bytes_mv;

	logic                evict_now, nr_final, slot_ok;
	logic [AW-1:0]       slot;
	logic [CNT_W-1:0]    c_after;
	logic [BYTES_W-1:0]  b_after;
	logic [2:0]          p_st;
	logic                p_pres;
	logic [63:0]         p_ev;
	logic [SIZE_W-1:0]   p_es;
	logic                p_kill_en, p_mru_en, p_ins_en, p_clr;
	logic [AW-1:0]       p_kill_idx, p_kill_rank, p_ins_idx;
	logic [CNT_W-1:0]    p_cnt;
	logic [BYTES_W-1:0]  p_bytes;
	logic [31:0]         p_hits, p_miss, p_evict, p_ins;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= RST_MAX_ENTRIES;
			max_bytes_q   <= RST_MAX_BYTES;
			ttl_q         <= RST_TTL_SECONDS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_ENTRIES: max_entries_q <= cfg_wdata[CNT_W-1:0];
				CFG_MAX_BYTES:   max_bytes_q   <= cfg_wdata[BYTES_W-1:0];
				CFG_TTL_SECONDS: ttl_q         <= cfg_wdata[TTL_W-1:0];
				default: ;
			endcase
		end
	end

	// memories
	assign sweep     = (state_q == S_INIT) || (state_q == S_SCAN) || (state_q == S_UPD);
	assign sweep_end = (cnt_q == CW'(ENTRIES));
	assign rk_re     = sweep && !sweep_end;
	assign dt_re     = (state_q == S_SCAN) && !sweep_end;
	assign rk_v      = rk_rdata[RKW-1];
	assign rk_r      = rk_rdata[AW-1:0];
	assign dt_ent    = entry_t'(dt_rdata);

	lkvc_ram #(.W(RKW), .DEPTH(ENTRIES), .AW(AW)) u_rank_ram (
		.clk   (clk),
		.we    (rk_we),
		.waddr (idx_s1),
		.wdata (rk_wdata),
		.re    (rk_re),
		.raddr (cnt_q[AW-1:0]),
		.rdata (rk_rdata)
	);

	lkvc_ram #(.W(EW), .DEPTH(ENTRIES), .AW(AW)) u_entry_ram (
		.clk   (clk),
		.we    (dt_we),
		.waddr (dt_waddr),
		.wdata (dt_wdata),
		.re    (dt_re),
		.raddr (cnt_q[AW-1:0]),
		.rdata (dt_rdata)
	);

	// rank and valid update of one swept entry
	always_comb begin
		upd_v = rk_v;
		upd_r = rk_r;
		if (clr_q) begin
			upd_v = 1'b0;
		end else if (kill_en_q && idx_s1 == kill_idx_q) begin
			upd_v = 1'b0;
		end else if (rk_v) begin
			if (mru_en_q) begin
				if (idx_s1 == mru_idx_q) begin
					upd_r = '0;
				end else if (rk_r < mru_rank_q) begin
					upd_r = rk_r + 1'b1;
				end
			end else if (kill_en_q && rk_r > kill_rank_q) begin
				upd_r = ins_en_q ? rk_r : rk_r - 1'b1;
			end else if (ins_en_q) begin
				upd_r = rk_r + 1'b1;
			end
		end
		if (!clr_q && ins_en_q && idx_s1 == ins_idx_q) begin
			upd_v = 1'b1;
			upd_r = '0;
		end
	end

	assign rk_we    = vld_s1 && ((state_q == S_UPD) || (state_q == S_INIT));
	assign rk_wdata = {upd_v, upd_r};

	// limit and expiry checks
	assign cap      = ({1'b0, max_entries_q} > ENT_CAP) ? ENT_CAP : {1'b0, max_entries_q};
	assign ttl_ms   = TTL_MS_W'(ttl_q) * MS_PER_SECOND;
	assign age      = req_q.now_ms - hent_q.created;
	assign expired_c = (ttl_q != '0) && (age >= 64'(ttl_ms));
	assign count_m1 = count_q - 1'b1;
	assign bytes_mv = bytes_q - BYTES_W'(vbytes_q);
	assign nr1_c = ({1'b0, count_q} >= cap) ||
		(({1'b0, bytes_q} + (BYTES_W+1)'(req_q.size_bytes)) > {1'b0, max_bytes_q});
	assign nr2_c = ({1'b0, count_m1} >= cap) ||
		(({1'b0, bytes_mv} + (BYTES_W+1)'(req_q.size_bytes)) > {1'b0, max_bytes_q});

	// decision
	assign evict_now = nr1_q && vfound_q;
	assign nr_final  = evict_now ? nr2_q : nr1_q;
	assign slot_ok   = ffound_q || evict_now;
	assign slot      = (evict_now && (!ffound_q || vidx_q < fidx_q)) ? vidx_q : fidx_q;
	assign c_after   = evict_now ? count_m1 : count_q;
	assign b_after   = evict_now ? bytes_mv : bytes_q;

	always_comb begin
		p_st        = ST_OK;
		p_pres      = 1'b0;
		p_ev        = '0;
		p_es        = '0;
		p_kill_en   = 1'b0;
		p_kill_idx  = hidx_q;
		p_kill_rank = hrank_q;
		p_mru_en    = 1'b0;
		p_ins_en    = 1'b0;
		p_ins_idx   = slot;
		p_clr       = 1'b0;
		p_cnt       = count_q;
		p_bytes     = bytes_q;
		p_hits      = hits_q;
		p_miss      = miss_q;
		p_evict     = evict_q;
		p_ins       = ins_q;
		dt_we       = 1'b0;
		dt_waddr    = hidx_q;
		dt_wdata    = hent_q;
		unique case (req_q.mode)
			MODE_PUT: begin
				if (req_q.size_bytes == '0) begin
					p_st = ST_BAD_SIZE;
				end else if (found_q) begin
					p_bytes  = bytes_q - BYTES_W'(hent_q.bytes) + BYTES_W'(req_q.size_bytes);
					p_mru_en = 1'b1;
					dt_we    = 1'b1;
					dt_wdata.payload = req_q.value;
					dt_wdata.bytes   = req_q.size_bytes;
				end else begin
					if (evict_now) begin
						p_kill_en   = 1'b1;
						p_kill_idx  = vidx_q;
						p_kill_rank = vrank_q;
						p_evict     = evict_q + 1'b1;
						p_cnt       = c_after;
						p_bytes     = b_after;
					end
					if (nr_final || !slot_ok) begin
						p_st = ST_FULL;
					end else begin
						p_ins_en = 1'b1;
						p_cnt    = c_after + 1'b1;
						p_bytes  = b_after + BYTES_W'(req_q.size_bytes);
						p_ins    = ins_q + 1'b1;
						dt_we    = 1'b1;
						dt_waddr = slot;
						dt_wdata = '{key: req_q.key, payload: req_q.value,
							bytes: req_q.size_bytes, created: req_q.now_ms};
					end
				end
			end
			MODE_GET: begin
				if (!found_q) begin
					p_miss = miss_q + 1'b1;
					p_st   = ST_NOT_FOUND;
				end else if (expired_q) begin
					p_kill_en = 1'b1;
					p_miss    = miss_q + 1'b1;
					p_st      = ST_EXPIRED;
					p_cnt     = count_m1;
					p_bytes   = bytes_q - BYTES_W'(hent_q.bytes);
				end else begin
					p_mru_en = 1'b1;
					p_hits   = hits_q + 1'b1;
					p_pres   = 1'b1;
					p_ev     = hent_q.payload;
					p_es     = hent_q.bytes;
				end
			end
			MODE_REMOVE: begin
				if (!found_q) begin
					p_st = ST_NOT_FOUND;
				end else begin
					p_kill_en = 1'b1;
					p_cnt     = count_m1;
					p_bytes   = bytes_q - BYTES_W'(hent_q.bytes);
				end
			end
			MODE_CONTAINS: begin
				p_pres = found_q;
				p_st   = found_q ? ST_OK : ST_NOT_FOUND;
			end
			MODE_CLEAR: begin
				p_clr   = 1'b1;
				p_cnt   = '0;
				p_bytes = '0;
				p_evict = '0;
			end
			MODE_STATS: begin
				p_hits  = '0;
				p_miss  = '0;
				p_evict = '0;
				p_ins   = '0;
			end
			default: ;
		endcase
		// entry store is written once, in the plan cycle
		if (state_q != S_PLAN) begin
			dt_we = 1'b0;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			cnt_q       <= '0;
			vld_s1      <= 1'b0;
			clr_q       <= 1'b1;
			kill_en_q   <= 1'b0;
			mru_en_q    <= 1'b0;
			ins_en_q    <= 1'b0;
			found_q     <= 1'b0;
			vfound_q    <= 1'b0;
			ffound_q    <= 1'b0;
			count_q     <= '0;
			bytes_q     <= '0;
			hits_q      <= '0;
			miss_q      <= '0;
			evict_q     <= '0;
			ins_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			vld_s1 <= sweep && !sweep_end;
			idx_s1 <= cnt_q[AW-1:0];
			if (sweep) begin
				cnt_q <= sweep_end ? '0 : cnt_q + 1'b1;
			end
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					if (sweep_end) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						req_q    <= req;
						found_q  <= 1'b0;
						vfound_q <= 1'b0;
						ffound_q <= 1'b0;
						state_q  <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (vld_s1) begin
						if (rk_v && dt_ent.key == req_q.key && !found_q) begin
							found_q <= 1'b1;
							hidx_q  <= idx_s1;
							hrank_q <= rk_r;
							hent_q  <= dt_ent;
						end
						if (rk_v && (!vfound_q || rk_r > vrank_q)) begin
							vfound_q <= 1'b1;
							vidx_q   <= idx_s1;
							vrank_q  <= rk_r;
							vbytes_q <= dt_ent.bytes;
						end
						if (!rk_v && !ffound_q) begin
							ffound_q <= 1'b1;
							fidx_q   <= idx_s1;
						end
					end
					if (sweep_end) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					expired_q <= expired_c;
					nr1_q     <= nr1_c;
					nr2_q     <= nr2_c;
					state_q   <= S_PLAN;
				end
				S_PLAN: begin
					st_q        <= p_st;
					pres_q      <= p_pres;
					ev_q        <= p_ev;
					es_q        <= p_es;
					kill_en_q   <= p_kill_en;
					kill_idx_q  <= p_kill_idx;
					kill_rank_q <= p_kill_rank;
					mru_en_q    <= p_mru_en;
					mru_idx_q   <= hidx_q;
					mru_rank_q  <= hrank_q;
					ins_en_q    <= p_ins_en;
					ins_idx_q   <= p_ins_idx;
					clr_q       <= p_clr;
					count_q     <= p_cnt;
					bytes_q     <= p_bytes;
					hits_q      <= p_hits;
					miss_q      <= p_miss;
					evict_q     <= p_evict;
					ins_q       <= p_ins;
					state_q     <= (p_kill_en || p_mru_en || p_ins_en || p_clr) ? S_UPD : S_FIN;
				end
				S_UPD: begin
					if (sweep_end) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q <= '{status: st_q, present: pres_q, entry_value: ev_q,
							entry_size: es_q, entries_used: count_q, bytes_used: bytes_q,
							hit_count: hits_q, miss_count: miss_q,
							eviction_count: evict_q, insert_count: ins_q};
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_FIN))
		else $error("response raised outside finish");

	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == S_SCAN) && !found_q && !vfound_q)
		else $error("accepted word did not start a clean scan");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= ENTRIES)
		else $error("entry count above capacity");

	a_hit_key: assert property (@(posedge clk) disable iff (!arst_n)
		(found_q && state_q == S_PLAN) |-> (hent_q.key == req_q.key))
		else $error("hit slot key differs from request key");

	a_evict_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PLAN && req_q.mode == MODE_PUT) |=>
		(evict_q == $past(evict_q)) || (evict_q == $past(evict_q) + 32'd1))
		else $error("put evicted more than once");

endmodule
`default_nettype wire
